### hw/rtl/u16u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and helper functions of the UTF-16 to UTF-8
// transcoder: job descriptor, result kinds and UTF-8 byte formatting.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // Width of the per-string byte counter (saturating)
  localparam int COUNT_BITS = 16;
  // Width of the reported byte total
  localparam int TOT_W      = 16;
  // Width wide enough for counter + width + 2 against the capacity
  localparam int SUM_W      = ((COUNT_BITS > TOT_W) ? COUNT_BITS : TOT_W) + 2;

  localparam int UNIT_W     = 16;
  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;
  localparam int NB_W       = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = CFG_IDX_W'(1);

  localparam logic [TOT_W-1:0] CAPACITY_RESET = 16'hFFFF;

  // Job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // UTF-8 lead and continuation prefixes
  localparam logic [BYTE_W-1:0] LEAD2 = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4 = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT  = 8'h80;
  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TERM = 2'd1,
    KIND_OVER = 2'd2
  } kind_t;

  // What closes a job after its data bytes
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_TERM = 2'd1,
    TAIL_OVER = 2'd2
  } tail_t;

  // One accepted unit's worth of results
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [NB_W-1:0]  nbytes;
    tail_t            tail;
    logic [TOT_W-1:0] tot_pre;
    logic [TOT_W-1:0] tot_tail;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Clamp the counter into the reported total
  function automatic logic [TOT_W-1:0] sat_tot(input logic [COUNT_BITS-1:0] v);
    logic [SUM_W-1:0] ext;
    ext = SUM_W'(v);
    if (ext > SUM_W'(CAPACITY_RESET)) begin
      return CAPACITY_RESET;
    end
    return ext[TOT_W-1:0];
  endfunction

  // Number of UTF-8 bytes for a code point
  function automatic logic [NB_W-1:0] utf8_width(input logic [CP_W-1:0] cp);
    if (cp < CP_W'(21'h80)) begin
      return NB_W'(1);
    end else if (cp < CP_W'(21'h800)) begin
      return NB_W'(2);
    end else if (cp < SUPP_BASE) begin
      return NB_W'(3);
    end
    return NB_W'(4);
  endfunction

  // Byte idx of the UTF-8 form of cp, which is nbytes long
  function automatic logic [BYTE_W-1:0] utf8_byte(input logic [CP_W-1:0] cp,
                                                  input logic [NB_W-1:0] nbytes,
                                                  input logic [NB_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    case (nbytes)
      NB_W'(1): b = cp[7:0];
      NB_W'(2): begin
        case (idx)
          NB_W'(0): b = LEAD2 | {3'b000, cp[10:6]};
          default:  b = CONT  | {2'b00, cp[5:0]};
        endcase
      end
      NB_W'(3): begin
        case (idx)
          NB_W'(0): b = LEAD3 | {4'b0000, cp[15:12]};
          NB_W'(1): b = CONT  | {2'b00, cp[11:6]};
          default:  b = CONT  | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          NB_W'(0): b = LEAD4 | {5'b00000, cp[20:18]};
          NB_W'(1): b = CONT  | {2'b00, cp[17:12]};
          NB_W'(2): b = CONT  | {2'b00, cp[11:6]};
          default:  b = CONT  | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/u16u8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, checks capacity, keeps the string
// state and the configuration registers, and pushes one job per unit that
// causes results.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [u16u8_pkg::UNIT_W-1:0]     in_code_unit,
  input  logic                             in_is_final,
  input  logic                             cfg_we,
  input  logic [u16u8_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [u16u8_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  u16u8_pkg::q_stat_t               q_stat,
  output logic                             push_valid,
  output u16u8_pkg::job_t                  push_job
);
  import u16u8_pkg::*;

  logic                  limit_en_r;
  logic [TOT_W-1:0]      capacity_r;
  logic [9:0]            pend_r, pend_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [COUNT_BITS-1:0] bw_r, bw_nxt;
  logic                  discard_r, discard_nxt;

  logic                  accept;
  logic                  is_zero, is_high, is_low;
  logic                  have_cp, over;
  logic [CP_W-1:0]       cp;
  logic [NB_W-1:0]       width;
  logic [COUNT_BITS:0]   bw_sum;
  logic [COUNT_BITS-1:0] bw_grown;
  logic [SUM_W-1:0]      need;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Classify the incoming unit
  assign is_zero = (in_code_unit == '0);
  assign is_high = (in_code_unit[15:10] == 6'b110110);
  assign is_low  = (in_code_unit[15:10] == 6'b110111);

  // Code point from the unit or the held surrogate pair
  always_comb begin
    have_cp = 1'b0;
    cp      = '0;
    if (pend_v_r) begin
      if (is_low) begin
        have_cp = 1'b1;
        cp      = {1'b0, pend_r, in_code_unit[9:0]} + SUPP_BASE;
      end
    end else if (!is_high) begin
      have_cp = 1'b1;
      cp      = CP_W'(in_code_unit);
    end
  end

  assign width    = utf8_width(cp);
  assign need     = SUM_W'(bw_r) + SUM_W'(width) + SUM_W'(2);
  assign over     = limit_en_r && (need > SUM_W'(capacity_r));
  assign bw_sum   = {1'b0, bw_r} + (COUNT_BITS + 1)'(width);
  assign bw_grown = bw_sum[COUNT_BITS] ? '1 : bw_sum[COUNT_BITS-1:0];

  // String state update and job build
  always_comb begin
    pend_nxt         = pend_r;
    pend_v_nxt       = pend_v_r;
    bw_nxt           = bw_r;
    discard_nxt      = discard_r;
    push_valid       = 1'b0;
    push_job.cp      = cp;
    push_job.nbytes  = '0;
    push_job.tail    = TAIL_NONE;
    push_job.tot_pre = sat_tot(bw_r);
    push_job.tot_tail = sat_tot(bw_r);
    if (accept) begin
      if (discard_r) begin
        if (is_zero || in_is_final) begin
          pend_nxt    = '0;
          pend_v_nxt  = 1'b0;
          bw_nxt      = '0;
          discard_nxt = 1'b0;
        end
      end else if (is_zero) begin
        push_valid    = 1'b1;
        push_job.tail = TAIL_TERM;
        pend_nxt      = '0;
        pend_v_nxt    = 1'b0;
        bw_nxt        = '0;
      end else begin
        // Drop or hold surrogates
        if (pend_v_r) begin
          pend_nxt   = '0;
          pend_v_nxt = 1'b0;
        end else if (is_high && !in_is_final) begin
          pend_nxt   = in_code_unit[9:0];
          pend_v_nxt = 1'b1;
        end
        if (have_cp && over) begin
          push_valid    = 1'b1;
          push_job.tail = TAIL_OVER;
          if (in_is_final) begin
            pend_nxt   = '0;
            pend_v_nxt = 1'b0;
            bw_nxt     = '0;
          end else begin
            discard_nxt = 1'b1;
          end
        end else begin
          if (have_cp) begin
            push_valid      = 1'b1;
            push_job.nbytes = width;
            bw_nxt          = bw_grown;
          end
          if (in_is_final) begin
            push_valid        = 1'b1;
            push_job.tail     = TAIL_TERM;
            push_job.tot_tail = sat_tot(have_cp ? bw_grown : bw_r);
            pend_nxt          = '0;
            pend_v_nxt        = 1'b0;
            bw_nxt            = '0;
          end
        end
      end
    end
  end

  // Hold string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      pend_v_r  <= 1'b0;
      bw_r      <= '0;
      discard_r <= 1'b0;
    end else begin
      pend_r    <= pend_nxt;
      pend_v_r  <= pend_v_nxt;
      bw_r      <= bw_nxt;
      discard_r <= discard_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_en_r <= 1'b0;
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT_ENABLE: limit_en_r <= cfg_wdata[0];
        REG_OUT_CAPACITY: capacity_r <= cfg_wdata[TOT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/u16u8_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue that decouples the front classifier from the byte
// serializer. The head entry is visible without a pop.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  u16u8_pkg::job_t    push_job,
  input  logic               pop,
  output u16u8_pkg::job_t    head_job,
  output u16u8_pkg::q_stat_t q_stat
);
  import u16u8_pkg::*;

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = mem_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the job beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### hw/rtl/u16u8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the head job one result per cycle while the output stage is not
// stalled: its UTF-8 bytes, then the terminator or overflow result, into a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u16u8_pkg::job_t               head_job,
  input  u16u8_pkg::q_stat_t            q_stat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u16u8_pkg::BYTE_W-1:0]  out_data_byte,
  output logic [1:0]                    out_result_kind,
  output logic [u16u8_pkg::TOT_W-1:0]   out_byte_total,
  output logic                          out_run_end
);
  import u16u8_pkg::*;

  logic [NB_W-1:0]   step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  kind_t             kind_r;
  logic [TOT_W-1:0]  tot_r;
  logic              end_r;

  logic [NB_W-1:0]   n_res;
  logic              last_step, is_data, load;
  logic [BYTE_W-1:0] byte_nxt;
  kind_t             kind_nxt;
  logic [TOT_W-1:0]  tot_nxt;

  assign n_res     = head_job.nbytes + NB_W'(head_job.tail != TAIL_NONE);
  assign last_step = (step_r == n_res - 1'b1);
  assign is_data   = (step_r < head_job.nbytes);
  assign load      = !q_stat.empty && (!out_valid_r || !out_stall);
  assign pop       = load && last_step;

  // Pick the result for this step
  always_comb begin
    byte_nxt = '0;
    kind_nxt = KIND_BYTE;
    tot_nxt  = head_job.tot_pre;
    if (is_data) begin
      byte_nxt = utf8_byte(head_job.cp, head_job.nbytes, step_r);
    end else begin
      tot_nxt = head_job.tot_tail;
      case (head_job.tail)
        TAIL_OVER: kind_nxt = KIND_OVER;
        default:   kind_nxt = KIND_TERM;
      endcase
    end
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      step_nxt      = last_step ? '0 : step_r + 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output beat
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      tot_r  <= tot_nxt;
      end_r  <= last_step;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_byte   = byte_r;
  assign out_result_kind = kind_r;
  assign out_byte_total  = tot_r;
  assign out_run_end     = end_r;

endmodule

### hw/rtl/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// An accepted unit is stored as a job in the queue, and its first result
// is then registered in the output stage. A unit causes up to 5 results
// (four bytes and a terminator), all through the single output byte register.
// A four-entry job queue lets input run ahead while results are stalled.
// Reset (rst_n low, synchronous) empties the queue and output stage, clears
// the string state and sets limit_enable = 0, out_capacity = 65535.
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Top level: front classifier, job queue and byte serializer.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [u16u8_pkg::UNIT_W-1:0]     in_code_unit,
  input  logic                             in_is_final,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [u16u8_pkg::BYTE_W-1:0]     out_data_byte,
  output logic [1:0]                       out_result_kind,
  output logic [u16u8_pkg::TOT_W-1:0]      out_byte_total,
  output logic                             out_run_end,
  input  logic                             cfg_we,
  input  logic [u16u8_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [u16u8_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import u16u8_pkg::*;

  logic    push_valid;
  job_t    push_job;
  job_t    head_job;
  logic    pop;
  q_stat_t q_stat;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_unit (in_code_unit),
    .in_is_final  (in_is_final),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_stat       (q_stat),
    .push_valid   (push_valid),
    .push_job     (push_job)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .head_job   (head_job),
    .q_stat     (q_stat)
  );

  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_result_kind (out_result_kind),
    .out_byte_total  (out_byte_total),
    .out_run_end     (out_run_end)
  );

  // Terminator and overflow always close the results of their unit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_TERM || out_result_kind == KIND_OVER)
    |-> out_run_end)
    else $error("closing result without run_end");

  // Only defined result kinds leave the block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == KIND_BYTE || out_result_kind == KIND_TERM ||
                   out_result_kind == KIND_OVER))
    else $error("undefined result kind");

  // Non-byte results carry a zero data byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_BYTE |-> out_data_byte == '0)
    else $error("nonzero data on terminator or overflow");

  // Output stage is empty right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A job is never pushed into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !q_stat.full)
    else $error("push into full job queue");

endmodule

### bench/utf16_to_utf8_transcoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A queue of code
// units feeds a valid/stall driver; every accepted beat runs through a local
// transcoder model that queues the UTF-8 bytes, terminators and overflow
// results it must cause. A monitor pops and compares each output beat field
// by field. Runs directed corner units and random strings under several
// capacity settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_tb;
  import u16u8_pkg::*;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [15:0] NUL_UNIT   = 16'h0000;
  localparam logic [20:0] SUPP_FIRST = 21'h10000;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [15:0] code_unit;
    logic        is_final;
  } unit_item_t;

  typedef struct {
    logic [7:0]  data_byte;
    kind_t       kind;
    logic [15:0] total;
    logic        run_end;
  } utf8_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [UNIT_W-1:0]       in_code_unit = '0;
  logic                    in_is_final = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [BYTE_W-1:0]       out_data_byte;
  logic [1:0]              out_result_kind;
  logic [TOT_W-1:0]        out_byte_total;
  logic                    out_run_end;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // Pending input units, expected output beats, rows of the current step
  unit_item_t unit_q[$];
  unit_item_t str_buf[$];
  utf8_row_t  utf8_exp_q[$];
  utf8_row_t  step_rows[$];

  // Local copy of registers and string state
  logic        lim_en = 1'b0;
  logic [15:0] cap = 16'hFFFF;
  logic [9:0]  pend_high = '0;
  logic        pend_valid = 1'b0;
  logic [15:0] bytes_cnt = '0;
  logic        discarding = 1'b0;

  int  mismatch_count = 0;
  int  tx_gap = 0;
  int  tx_calm_left = 0;
  int  rx_hold = 0;
  int  rx_calm_left = 0;

  utf16_to_utf8_transcoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_unit    (in_code_unit),
    .in_is_final     (in_is_final),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_result_kind (out_result_kind),
    .out_byte_total  (out_byte_total),
    .out_run_end     (out_run_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ERROR %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Idle length: mostly zero or short, a few long, with calm stretches
  function automatic int pick_idle(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic unit_item_t mk_unit(input logic [15:0] cu, input logic fin);
    unit_item_t u;
    u.code_unit = cu;
    u.is_final  = fin;
    return u;
  endfunction

  function automatic void clear_string_state();
    pend_high  = '0;
    pend_valid = 1'b0;
    bytes_cnt  = '0;
    discarding = 1'b0;
  endfunction

  // Rows carry the byte count before the current code point; a closing terminator carries it after
  function automatic void add_row(input logic [7:0] b, input kind_t k);
    utf8_row_t row;
    row.data_byte = b;
    row.kind      = k;
    row.total     = bytes_cnt;
    row.run_end   = 1'b0;
    step_rows.push_back(row);
  endfunction

  // Work out the beats that one accepted code unit causes
  task automatic transcode_unit(input logic [15:0] cu, input logic fin);
    logic [20:0] cp;
    logic [20:0] chunk;
    logic [7:0]  lead;
    logic        have_cp;
    logic        overflowed;
    logic [17:0] need;
    logic [16:0] sum;
    int          w;
    step_rows.delete();
    cp = '0;
    have_cp = 1'b0;
    overflowed = 1'b0;
    if (discarding) begin
      if (cu == NUL_UNIT || fin) clear_string_state();
      return;
    end
    if (cu == NUL_UNIT) begin
      add_row(8'h00, KIND_TERM);
      clear_string_state();
    end else begin
      // Pair up or drop a held high surrogate, or hold a new one
      if (pend_valid) begin
        if (cu >= LOW_FIRST && cu <= LOW_LAST) begin
          cp = ((21'(pend_high) << 10) | 21'(cu - LOW_FIRST)) + SUPP_FIRST;
          have_cp = 1'b1;
        end
        pend_valid = 1'b0;
        pend_high  = '0;
      end else if (cu >= HIGH_FIRST && cu <= HIGH_LAST) begin
        if (!fin) begin
          pend_high  = 10'(cu - HIGH_FIRST);
          pend_valid = 1'b1;
        end
      end else begin
        cp = 21'(cu);
        have_cp = 1'b1;
      end
      if (have_cp) begin
        w = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < SUPP_FIRST) ? 3 : 4;
        need = 18'(bytes_cnt) + 18'(w) + 18'd2;
        if (lim_en && need > 18'(cap)) begin
          add_row(8'h00, KIND_OVER);
          overflowed = 1'b1;
          if (fin) clear_string_state();
          else discarding = 1'b1;
        end else begin
          case (w)
            2:       lead = UTF8_LEAD2;
            3:       lead = UTF8_LEAD3;
            4:       lead = UTF8_LEAD4;
            default: lead = 8'h00;
          endcase
          for (int k = w - 1; k >= 0; k--) begin
            chunk = cp >> (6 * k);
            if (k == w - 1) add_row(lead | chunk[7:0], KIND_BYTE);
            else add_row(UTF8_CONT | {2'b00, chunk[5:0]}, KIND_BYTE);
          end
          // Saturate the per-string count
          sum = 17'(bytes_cnt) + 17'(w);
          bytes_cnt = sum[16] ? 16'hFFFF : sum[15:0];
        end
      end
      if (fin && !overflowed) begin
        add_row(8'h00, KIND_TERM);
        clear_string_state();
      end
    end
    if (step_rows.size() > 0) step_rows[step_rows.size() - 1].run_end = 1'b1;
    foreach (step_rows[i]) utf8_exp_q.push_back(step_rows[i]);
  endtask

  // Drive input beats; predict on each accepted beat
  always @(posedge clk) begin : drive_units
    unit_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) transcode_unit(in_code_unit, in_is_final);
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (unit_q.size() > 0) begin
          nxt = unit_q.pop_front();
          in_valid     <= 1'b1;
          in_code_unit <= nxt.code_unit;
          in_is_final  <= nxt.is_final;
          tx_gap = pick_idle(tx_calm_left);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted output beat against the oldest expectation
  always @(posedge clk) begin : check_bytes
    utf8_row_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (utf8_exp_q.size() == 0) begin
          report_mismatch("unexpected beat, kind", 32'(out_result_kind), 32'hFFFF_FFFF);
        end else begin
          want = utf8_exp_q.pop_front();
          if (out_data_byte !== want.data_byte)
            report_mismatch("data_byte", 32'(out_data_byte), 32'(want.data_byte));
          if (out_result_kind !== want.kind)
            report_mismatch("result_kind", 32'(out_result_kind), 32'(want.kind));
          if (out_byte_total !== want.total)
            report_mismatch("byte_total", 32'(out_byte_total), 32'(want.total));
          if (out_run_end !== want.run_end)
            report_mismatch("run_end", 32'(out_run_end), 32'(want.run_end));
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_hold = pick_idle(rx_calm_left);
      end
    end
  end

  // Hold until all units are sent and all beats are back, then settle
  task automatic wait_idle();
    do @(negedge clk);
    while (unit_q.size() != 0 || in_valid || utf8_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LIMIT_ENABLE) lim_en = val[0];
    else cap = val;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_bmp3();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(16'h0800, 16'hD7FF));
    return 16'($urandom_range(16'hE000, 16'hFFFF));
  endfunction

  // Append one random character (one or two units) to the string buffer
  function automatic void add_random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      str_buf.push_back(mk_unit(16'($urandom_range(1, 127)), 1'b0));
    end else if (r < 42) begin
      str_buf.push_back(mk_unit(16'($urandom_range(16'h0080, 16'h07FF)), 1'b0));
    end else if (r < 57) begin
      str_buf.push_back(mk_unit(rand_bmp3(), 1'b0));
    end else if (r < 77) begin
      str_buf.push_back(mk_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0));
      str_buf.push_back(mk_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), 1'b0));
    end else if (r < 82) begin
      str_buf.push_back(mk_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), 1'b0));
    end else if (r < 87) begin
      // High surrogate followed by something that is not a low one
      str_buf.push_back(mk_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0));
      if ($urandom_range(0, 1) == 0)
        str_buf.push_back(mk_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0));
      else
        str_buf.push_back(mk_unit(16'($urandom_range(1, 16'hD7FF)), 1'b0));
    end else if (r < 90) begin
      str_buf.push_back(mk_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0));
    end else begin
      str_buf.push_back(mk_unit(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1))));
    end
  endfunction

  // Queue random strings until about n units are pending
  task automatic queue_random(input int n);
    int added;
    int len;
    int ending;
    added = 0;
    while (added < n) begin
      str_buf.delete();
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 30);
      repeat (len) add_random_char();
      ending = $urandom_range(0, 9);
      if (ending < 5) str_buf.push_back(mk_unit(NUL_UNIT, 1'($urandom_range(0, 1))));
      else if (ending < 9) str_buf[str_buf.size() - 1].is_final = 1'b1;
      // otherwise run on into the next string
      foreach (str_buf[i]) unit_q.push_back(str_buf[i]);
      added += str_buf.size();
    end
  endtask

  initial begin : run_test
    int cap_plan[10];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Width boundaries, surrogate pairing and string endings, no limit
    unit_q.push_back(mk_unit(16'h0041, 1'b0));
    unit_q.push_back(mk_unit(16'h007F, 1'b0));
    unit_q.push_back(mk_unit(16'h0080, 1'b0));
    unit_q.push_back(mk_unit(16'h07FF, 1'b0));
    unit_q.push_back(mk_unit(16'h0800, 1'b0));
    unit_q.push_back(mk_unit(16'hFFFF, 1'b0));
    unit_q.push_back(mk_unit(LOW_FIRST, 1'b0));
    unit_q.push_back(mk_unit(HIGH_FIRST, 1'b0));
    unit_q.push_back(mk_unit(LOW_FIRST, 1'b0));
    unit_q.push_back(mk_unit(HIGH_LAST, 1'b0));
    unit_q.push_back(mk_unit(LOW_LAST, 1'b0));
    unit_q.push_back(mk_unit(16'hD801, 1'b0));
    unit_q.push_back(mk_unit(16'h0041, 1'b0));
    unit_q.push_back(mk_unit(16'hDA00, 1'b0));
    unit_q.push_back(mk_unit(16'hDB00, 1'b0));
    unit_q.push_back(mk_unit(NUL_UNIT, 1'b0));
    unit_q.push_back(mk_unit(16'hD805, 1'b0));
    unit_q.push_back(mk_unit(NUL_UNIT, 1'b0));
    unit_q.push_back(mk_unit(HIGH_LAST, 1'b1));
    unit_q.push_back(mk_unit(16'h00E9, 1'b1));
    unit_q.push_back(mk_unit(NUL_UNIT, 1'b1));
    unit_q.push_back(mk_unit(16'hD7FF, 1'b0));
    unit_q.push_back(mk_unit(16'hE000, 1'b0));
    unit_q.push_back(mk_unit(16'h0001, 1'b1));
    wait_idle();
    queue_random(60);
    wait_idle();

    // Tight capacity: overflow, discard until string end, final overflow
    write_reg(REG_LIMIT_ENABLE, 16'd1);
    write_reg(REG_OUT_CAPACITY, 16'd5);
    repeat (4) unit_q.push_back(mk_unit(16'h0041, 1'b0));
    unit_q.push_back(mk_unit(16'h0042, 1'b0));
    unit_q.push_back(mk_unit(NUL_UNIT, 1'b0));
    unit_q.push_back(mk_unit(16'h00E9, 1'b0));
    unit_q.push_back(mk_unit(16'h20AC, 1'b1));
    unit_q.push_back(mk_unit(HIGH_FIRST, 1'b0));
    unit_q.push_back(mk_unit(LOW_FIRST, 1'b1));
    unit_q.push_back(mk_unit(16'h0041, 1'b1));
    queue_random(40);
    wait_idle();

    // Sweep capacities with the limit on
    cap_plan = '{0, 1, 2, 3, 8, 20, 64, 65535, 0, 0};
    cap_plan[8] = $urandom_range(4, 200);
    cap_plan[9] = $urandom_range(0, 16'hFFFF);
    foreach (cap_plan[i]) begin
      write_reg(REG_OUT_CAPACITY, 16'(cap_plan[i]));
      queue_random(30);
      wait_idle();
    end

    // Limit off with a capacity that would otherwise overflow at once
    write_reg(REG_LIMIT_ENABLE, 16'd0);
    write_reg(REG_OUT_CAPACITY, 16'd2);
    queue_random(40);
    wait_idle();

    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
